// ===== sv/msort_pkg.sv =====
// Package for the merge sorter: payload types, sizing constants and the
// microcode table of the sort sequencer. No dependencies.
package msort_pkg;

    localparam int CAPACITY = 64;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;
    localparam int STEP_W   = 4;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     last;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] sorted_value;
        logic                     end_of_set;
    } t_out_item;

    // Datapath actions selected by the control word.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_LO_ZERO,
        OP_RUN_INIT,
        OP_READ_I,
        OP_READ_J,
        OP_CAP_J,
        OP_MERGE,
        OP_FETCH,
        OP_NEXT_LO,
        OP_NEXT_W,
        OP_K_ZERO,
        OP_OUT_ADDR,
        OP_OUT_LOAD
    } t_op;

    // Jump conditions; the sequencer jumps when the condition holds.
    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NOT_END,
        C_W_GE_N,
        C_K_LT_HI,
        C_MORE_RUNS,
        C_OUT_BUSY,
        C_K_LT_N
    } t_cond;

    typedef struct packed {
        t_op               op;
        t_cond             cond;
        logic [STEP_W-1:0] target;
    } t_ctrl;

    // Step addresses of the microprogram.
    localparam logic [STEP_W-1:0] S_LOAD     = 4'd0;
    localparam logic [STEP_W-1:0] S_CHKW     = 4'd1;
    localparam logic [STEP_W-1:0] S_LOINIT   = 4'd2;
    localparam logic [STEP_W-1:0] S_RUN      = 4'd3;
    localparam logic [STEP_W-1:0] S_RDI      = 4'd4;
    localparam logic [STEP_W-1:0] S_RDJ      = 4'd5;
    localparam logic [STEP_W-1:0] S_CAPJ     = 4'd6;
    localparam logic [STEP_W-1:0] S_MERGE    = 4'd7;
    localparam logic [STEP_W-1:0] S_FETCH    = 4'd8;
    localparam logic [STEP_W-1:0] S_NEXTRUN  = 4'd9;
    localparam logic [STEP_W-1:0] S_NEXTPASS = 4'd10;
    localparam logic [STEP_W-1:0] S_OUT      = 4'd11;
    localparam logic [STEP_W-1:0] S_ORD      = 4'd12;
    localparam logic [STEP_W-1:0] S_OSEND    = 4'd13;
    localparam logic [STEP_W-1:0] S_OCHK     = 4'd14;
    localparam logic [STEP_W-1:0] S_DONE     = 4'd15;

    function automatic t_ctrl ucode_rom(input logic [STEP_W-1:0] step);
        t_ctrl w;
        w = '{op: OP_NONE, cond: C_NEVER, target: S_LOAD};
        case (step)
            S_LOAD:     w = '{op: OP_LOAD,     cond: C_NOT_END,   target: S_LOAD};
            S_CHKW:     w = '{op: OP_NONE,     cond: C_W_GE_N,    target: S_OUT};
            S_LOINIT:   w = '{op: OP_LO_ZERO,  cond: C_NEVER,     target: S_LOAD};
            S_RUN:      w = '{op: OP_RUN_INIT, cond: C_NEVER,     target: S_LOAD};
            S_RDI:      w = '{op: OP_READ_I,   cond: C_NEVER,     target: S_LOAD};
            S_RDJ:      w = '{op: OP_READ_J,   cond: C_NEVER,     target: S_LOAD};
            S_CAPJ:     w = '{op: OP_CAP_J,    cond: C_NEVER,     target: S_LOAD};
            S_MERGE:    w = '{op: OP_MERGE,    cond: C_NEVER,     target: S_LOAD};
            S_FETCH:    w = '{op: OP_FETCH,    cond: C_K_LT_HI,   target: S_MERGE};
            S_NEXTRUN:  w = '{op: OP_NEXT_LO,  cond: C_MORE_RUNS, target: S_RUN};
            S_NEXTPASS: w = '{op: OP_NEXT_W,   cond: C_ALWAYS,    target: S_CHKW};
            S_OUT:      w = '{op: OP_K_ZERO,   cond: C_NEVER,     target: S_LOAD};
            S_ORD:      w = '{op: OP_OUT_ADDR, cond: C_NEVER,     target: S_LOAD};
            S_OSEND:    w = '{op: OP_OUT_LOAD, cond: C_OUT_BUSY,  target: S_OSEND};
            S_OCHK:     w = '{op: OP_NONE,     cond: C_K_LT_N,    target: S_ORD};
            S_DONE:     w = '{op: OP_NONE,     cond: C_ALWAYS,    target: S_LOAD};
            default:    w = '{op: OP_NONE,     cond: C_ALWAYS,    target: S_LOAD};
        endcase
        return w;
    endfunction

endpackage

// ===== sv/msort_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Standalone; no package dependency.
module msort_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/merge_sorter.sv =====
// Merge sorter: loads up to CAPACITY values, sorts them by bottom-up merge
// passes between two RAM banks, then streams them out in ascending order.
// Loading writes each accepted item into bank 0. Each pass merges pairs of runs,
// reading both run heads and then one element at a time through the single
// registered read port of the banks. Output waits while i_ready is low.
// Reset (synchronous, active low) clears the sequencer, the load count and
// the output valid flag; RAM contents need no clearing.
module merge_sorter
    import msort_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_item  i_data,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_data
);

    logic [STEP_W-1:0] r_step, n_step;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  r_n;
    logic [CNT_W-1:0]  r_width;
    logic [CNT_W-1:0]  r_lo, r_mid, r_hi, r_i, r_j, r_k;
    logic              r_bank;
    logic              r_took_a;
    logic [DATA_W-1:0] r_head_a, r_head_b;
    logic              r_o_valid;
    t_out_item         r_o_data;

    t_ctrl             w_ctrl;
    logic              w_accept, w_end, w_jump, w_take_a, w_out_busy;
    logic [CNT_W:0]    w_lo_w, w_lo_2w;
    logic [CNT_W-1:0]  w_mid, w_hi;
    logic [ADDR_W-1:0] w_raddr, w_waddr;
    logic [DATA_W-1:0] w_wdata, w_rdata, w_rdata0, w_rdata1;
    logic              w_we0, w_we1;

    assign w_ctrl     = ucode_rom(r_step);
    assign o_ready    = (w_ctrl.op == OP_LOAD);
    assign w_accept   = i_valid && o_ready;
    assign w_end      = i_data.last || (r_count == CNT_W'(CAPACITY - 1));
    assign w_out_busy = r_o_valid && !i_ready;

    assign w_lo_w  = {1'b0, r_lo} + {1'b0, r_width};
    assign w_lo_2w = w_lo_w + {1'b0, r_width};
    assign w_mid   = (w_lo_w  > {1'b0, r_n}) ? r_n : w_lo_w[CNT_W-1:0];
    assign w_hi    = (w_lo_2w > {1'b0, r_n}) ? r_n : w_lo_2w[CNT_W-1:0];

    // Left wins if its run lasts and right is done or not smaller (stable merge).
    assign w_take_a = (r_i < r_mid)
                   && ((r_j >= r_hi) || ($signed(r_head_a) <= $signed(r_head_b)));

    assign w_rdata = r_bank ? w_rdata1 : w_rdata0;

    always_comb begin
        case (w_ctrl.cond)
            C_NEVER:     w_jump = 1'b0;
            C_ALWAYS:    w_jump = 1'b1;
            C_NOT_END:   w_jump = !(w_accept && w_end);
            C_W_GE_N:    w_jump = (r_width >= r_n);
            C_K_LT_HI:   w_jump = (r_k < r_hi);
            C_MORE_RUNS: w_jump = (w_lo_2w < {1'b0, r_n});
            C_OUT_BUSY:  w_jump = w_out_busy;
            C_K_LT_N:    w_jump = (r_k < r_n);
            default:     w_jump = 1'b0;
        endcase
        n_step = w_jump ? w_ctrl.target : r_step + STEP_W'(1);
    end

    // Read address and the write port of both banks.
    always_comb begin
        w_raddr = r_k[ADDR_W-1:0];
        case (w_ctrl.op)
            OP_READ_I: w_raddr = r_i[ADDR_W-1:0];
            OP_READ_J: w_raddr = r_j[ADDR_W-1:0];
            OP_MERGE:  w_raddr = w_take_a ? ADDR_W'(r_i + CNT_W'(1))
                                          : ADDR_W'(r_j + CNT_W'(1));
            default:   w_raddr = r_k[ADDR_W-1:0];
        endcase

        w_we0   = 1'b0;
        w_we1   = 1'b0;
        w_waddr = r_k[ADDR_W-1:0];
        w_wdata = w_take_a ? r_head_a : r_head_b;
        if (w_ctrl.op == OP_LOAD) begin
            w_we0   = w_accept;
            w_waddr = r_count[ADDR_W-1:0];
            w_wdata = i_data.value;
        end else if (w_ctrl.op == OP_MERGE) begin
            w_we0 = r_bank;
            w_we1 = !r_bank;
        end
    end

    msort_ram #(.WIDTH(DATA_W), .DEPTH(CAPACITY)) u_bank0 (
        .i_clk   (i_clk),
        .i_we    (w_we0),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata0)
    );

    msort_ram #(.WIDTH(DATA_W), .DEPTH(CAPACITY)) u_bank1 (
        .i_clk   (i_clk),
        .i_we    (w_we1),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata1)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step    <= S_LOAD;
            r_count   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_step <= n_step;
            // The output step sets the flag itself when it loads a new result.
            if (r_o_valid && i_ready && (w_ctrl.op != OP_OUT_LOAD)) begin
                r_o_valid <= 1'b0;
            end
            case (w_ctrl.op)
                OP_LOAD: begin
                    if (w_accept) begin
                        if (w_end) begin
                            r_n     <= r_count + CNT_W'(1);
                            r_count <= '0;
                            r_width <= CNT_W'(1);
                            r_bank  <= 1'b0;
                        end else begin
                            r_count <= r_count + CNT_W'(1);
                        end
                    end
                end
                OP_LO_ZERO: begin
                    r_lo <= '0;
                end
                OP_RUN_INIT: begin
                    r_mid <= w_mid;
                    r_hi  <= w_hi;
                    r_i   <= r_lo;
                    r_j   <= w_mid;
                    r_k   <= r_lo;
                end
                OP_READ_J: begin
                    r_head_a <= w_rdata;
                end
                OP_CAP_J: begin
                    r_head_b <= w_rdata;
                end
                OP_MERGE: begin
                    r_took_a <= w_take_a;
                    r_k      <= r_k + CNT_W'(1);
                    if (w_take_a) begin
                        r_i <= r_i + CNT_W'(1);
                    end else begin
                        r_j <= r_j + CNT_W'(1);
                    end
                end
                OP_FETCH: begin
                    if (r_took_a) begin
                        r_head_a <= w_rdata;
                    end else begin
                        r_head_b <= w_rdata;
                    end
                end
                OP_NEXT_LO: begin
                    r_lo <= w_lo_2w[CNT_W-1:0];
                end
                OP_NEXT_W: begin
                    r_width <= CNT_W'({r_width, 1'b0});
                    r_bank  <= !r_bank;
                end
                OP_K_ZERO: begin
                    r_k <= '0;
                end
                OP_OUT_LOAD: begin
                    if (!w_out_busy) begin
                        r_o_valid             <= 1'b1;
                        r_o_data.sorted_value <= w_rdata;
                        r_o_data.end_of_set   <= (r_k + CNT_W'(1) == r_n);
                        r_k                   <= r_k + CNT_W'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_valid = r_o_valid;
    assign o_data  = r_o_data;

endmodule
